FILE: src/lcal_pkg.sv
// Shared types and constants of the lowest common ancestor lifting unit.
`timescale 1ns / 1ps

package lcal_pkg;

    // Field widths fixed by the channel payloads.
    localparam int NODE_IN_W = 10;
    localparam int COUNT_W   = 11;
    localparam int DEPTH_W   = 10;
    localparam int ACTION_W  = 2;

    // Depth values saturate here for malformed trees.
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef logic [COUNT_W-1:0] lcal_count_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [NODE_IN_W-1:0] node_a;
        logic [NODE_IN_W-1:0] node_b;
    } lcal_item_t;

    typedef struct packed {
        logic [NODE_IN_W-1:0] ancestor;
        logic                 status;
    } lcal_result_t;

endpackage

FILE: src/lcal_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps

interface lcal_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/lcal_lift_unit.sv
// Shared lifting step: follows table entries and compares them.
`timescale 1ns / 1ps

module lcal_lift_unit #(
    parameter int NODE_W = 10
) (
    input  logic [NODE_W:0]   ent_u,
    input  logic [NODE_W:0]   ent_v,
    input  logic [NODE_W-1:0] node_u,
    input  logic [NODE_W-1:0] node_v,
    output logic [NODE_W-1:0] lift_u,
    output logic [NODE_W-1:0] lift_v,
    output logic              root_u,
    output logic              differ
);

    // The top bit of an entry marks "no ancestor"; a step onto it stays put.
    assign root_u = ent_u[NODE_W];
    assign lift_u = ent_u[NODE_W] ? node_u : ent_u[NODE_W-1:0];
    assign lift_v = ent_v[NODE_W] ? node_v : ent_v[NODE_W-1:0];
    assign differ = (ent_u != ent_v);

endmodule

FILE: src/lcal_engine.sv
// Sequencer, ancestor table and depth store of the lifting unit.
`timescale 1ns / 1ps

module lcal_engine #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               idle,
    input  lcal_pkg::lcal_item_t               item,
    input  logic [lcal_pkg::COUNT_W-1:0]       node_count,
    output logic                               res_valid,
    input  logic                               res_ready,
    output lcal_pkg::lcal_result_t             result
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int ENT_W  = NODE_W + 1;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W0 = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W0 > lcal_pkg::COUNT_W) ? CNT_W0 : lcal_pkg::COUNT_W;
    localparam int DEXT_W = (LEVELS > lcal_pkg::DEPTH_W) ? LEVELS : lcal_pkg::DEPTH_W;
    localparam logic [ENT_W-1:0] NO_ANC = {1'b1, {NODE_W{1'b0}}};
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BLD_A  = 4'd1;
    localparam logic [3:0] S_BLD_B  = 4'd2;
    localparam logic [3:0] S_BLD_W  = 4'd3;
    localparam logic [3:0] S_DEP_A  = 4'd4;
    localparam logic [3:0] S_DEP_W  = 4'd5;
    localparam logic [3:0] S_Q_SWAP = 4'd6;
    localparam logic [3:0] S_Q_LIFT = 4'd7;
    localparam logic [3:0] S_Q_DESC = 4'd8;
    localparam logic [3:0] S_Q_FIN  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [ENT_W-1:0]            anc_mem [LEVELS][MAX_NODES];
    logic [lcal_pkg::DEPTH_W-1:0] depth_mem [MAX_NODES];

    logic [3:0]                   state_reg, state_next;
    logic [LVL_W-1:0]             lvl_reg, lvl_next;
    logic [CMP_W-1:0]             cnt_reg, cnt_next;
    logic [NODE_W-1:0]            u_reg, u_next;
    logic [NODE_W-1:0]            v_reg, v_next;
    logic [lcal_pkg::DEPTH_W-1:0] diff_reg, diff_next;
    logic [LEVELS-1:0]            dacc_reg, dacc_next;
    lcal_pkg::lcal_result_t       res_reg, res_next;

    logic [ENT_W-1:0]             rd_a_reg, rd_b_reg;
    logic [lcal_pkg::DEPTH_W-1:0] dep_a_reg, dep_b_reg;

    // Memory port controls.
    logic                         aw_en;
    logic [LVL_W-1:0]             aw_lvl;
    logic [NODE_W-1:0]            aw_node;
    logic [ENT_W-1:0]             aw_data;
    logic                         ra_en, rb_en;
    logic [LVL_W-1:0]             ra_lvl, rb_lvl;
    logic [NODE_W-1:0]            ra_node, rb_node;
    logic                         dw_en, dr_en;
    logic [NODE_W-1:0]            dw_node, dr_a, dr_b;
    logic [lcal_pkg::DEPTH_W-1:0] dw_data;

    // Lifting unit results.
    logic [NODE_W-1:0]            lift_u, lift_v;
    logic                         root_u, differ;

    logic [CMP_W-1:0]             live_n, cnt_ext, a_ext, b_ext, cnt_inc, u_wide, fin_wide;
    logic                         a_bad, b_bad;
    logic [LVL_W-1:0]             lvl_dec, lvl_inc;
    logic [LEVELS-1:0]            dacc_new;
    logic [DEXT_W-1:0]            dacc_ext;
    logic [lcal_pkg::DEPTH_W-1:0] dsat;
    logic [NODE_W-1:0]            v_lifted, u_desc, v_desc;

    lcal_lift_unit #(
        .NODE_W (NODE_W)
    ) u_lift (
        .ent_u  (rd_a_reg),
        .ent_v  (rd_b_reg),
        .node_u (u_reg),
        .node_v (v_reg),
        .lift_u (lift_u),
        .lift_v (lift_v),
        .root_u (root_u),
        .differ (differ)
    );

    always_ff @(posedge clk)
    begin
        if (aw_en)
        begin
            anc_mem[aw_lvl][aw_node] <= aw_data;
        end
        if (ra_en)
        begin
            rd_a_reg <= anc_mem[ra_lvl][ra_node];
        end
        if (rb_en)
        begin
            rd_b_reg <= anc_mem[rb_lvl][rb_node];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            depth_mem[dw_node] <= dw_data;
        end
        if (dr_en)
        begin
            dep_a_reg <= depth_mem[dr_a];
            dep_b_reg <= depth_mem[dr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        cnt_reg  <= cnt_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        diff_reg <= diff_next;
        dacc_reg <= dacc_next;
        res_reg  <= res_next;
    end

    // Datapath helpers around the lifting unit.
    always_comb
    begin
        cnt_ext  = CMP_W'(node_count);
        live_n   = (cnt_ext < CMP_W'(MAX_NODES)) ? cnt_ext : CMP_W'(MAX_NODES);
        a_ext    = CMP_W'(item.node_a);
        b_ext    = CMP_W'(item.node_b);
        a_bad    = (a_ext >= live_n);
        b_bad    = (b_ext >= live_n);
        cnt_inc  = cnt_reg + CMP_W'(1);
        lvl_dec  = lvl_reg - LVL_W'(1);
        lvl_inc  = lvl_reg + LVL_W'(1);
        dacc_new = root_u ? dacc_reg : (dacc_reg | (LEVELS'(1) << lvl_reg));
        dacc_ext = DEXT_W'(dacc_new);
        dsat     = (dacc_ext > DEXT_W'(lcal_pkg::DEPTH_MAX)) ? lcal_pkg::DEPTH_MAX
                                                             : dacc_ext[lcal_pkg::DEPTH_W-1:0];
        v_lifted = diff_reg[0] ? lift_v : v_reg;
        u_desc   = differ ? lift_u : u_reg;
        v_desc   = differ ? lift_v : v_reg;
        u_wide   = CMP_W'(u_reg);
        fin_wide = CMP_W'(rd_a_reg[NODE_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        diff_next  = diff_reg;
        dacc_next  = dacc_reg;
        res_next   = res_reg;
        aw_en      = 1'b0;
        aw_lvl     = '0;
        aw_node    = '0;
        aw_data    = '0;
        ra_en      = 1'b0;
        ra_lvl     = '0;
        ra_node    = '0;
        rb_en      = 1'b0;
        rb_lvl     = '0;
        rb_node    = '0;
        dw_en      = 1'b0;
        dw_node    = '0;
        dw_data    = '0;
        dr_en      = 1'b0;
        dr_a       = '0;
        dr_b       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    case (item.action)
                        lcal_pkg::ACT_LOAD:
                        begin
                            if (a_bad || b_bad)
                            begin
                                res_next.status = lcal_pkg::STATUS_RANGE;
                            end
                            else if (b_ext != '0)
                            begin
                                // Edges onto the root are dropped; build marks it anyway.
                                aw_en   = 1'b1;
                                aw_node = b_ext[NODE_W-1:0];
                                aw_data = {1'b0, a_ext[NODE_W-1:0]};
                            end
                        end
                        lcal_pkg::ACT_BUILD:
                        begin
                            if (live_n != '0)
                            begin
                                aw_en    = 1'b1;
                                aw_data  = NO_ANC;
                                cnt_next = '0;
                                if (LEVELS > 1)
                                begin
                                    lvl_next   = LVL_W'(1);
                                    state_next = S_BLD_A;
                                end
                                else
                                begin
                                    state_next = S_DEP_A;
                                end
                            end
                        end
                        lcal_pkg::ACT_QUERY:
                        begin
                            if (a_bad || b_bad)
                            begin
                                res_next.status = lcal_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                u_next     = a_ext[NODE_W-1:0];
                                v_next     = b_ext[NODE_W-1:0];
                                dr_en      = 1'b1;
                                dr_a       = a_ext[NODE_W-1:0];
                                dr_b       = b_ext[NODE_W-1:0];
                                state_next = S_Q_SWAP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_BLD_A:
            begin
                ra_en      = 1'b1;
                ra_lvl     = lvl_dec;
                ra_node    = cnt_reg[NODE_W-1:0];
                state_next = S_BLD_B;
            end

            S_BLD_B:
            begin
                // Second hop: the ancestor of the ancestor, one level down.
                rb_en      = 1'b1;
                rb_lvl     = lvl_dec;
                rb_node    = rd_a_reg[NODE_W-1:0];
                state_next = S_BLD_W;
            end

            S_BLD_W:
            begin
                aw_en   = 1'b1;
                aw_lvl  = lvl_reg;
                aw_node = cnt_reg[NODE_W-1:0];
                aw_data = root_u ? NO_ANC : rd_b_reg;
                if (cnt_inc < live_n)
                begin
                    cnt_next   = cnt_inc;
                    ra_en      = 1'b1;
                    ra_lvl     = lvl_dec;
                    ra_node    = cnt_inc[NODE_W-1:0];
                    state_next = S_BLD_B;
                end
                else
                begin
                    cnt_next = '0;
                    if (lvl_reg == TOP_LVL)
                    begin
                        state_next = S_DEP_A;
                    end
                    else
                    begin
                        lvl_next   = lvl_inc;
                        state_next = S_BLD_A;
                    end
                end
            end

            S_DEP_A:
            begin
                u_next     = cnt_reg[NODE_W-1:0];
                dacc_next  = '0;
                lvl_next   = TOP_LVL;
                ra_en      = 1'b1;
                ra_lvl     = TOP_LVL;
                ra_node    = cnt_reg[NODE_W-1:0];
                state_next = S_DEP_W;
            end

            S_DEP_W:
            begin
                // Each level that has an ancestor adds its power of two to the depth.
                if (lvl_reg != '0)
                begin
                    u_next    = lift_u;
                    dacc_next = dacc_new;
                    lvl_next  = lvl_dec;
                    ra_en     = 1'b1;
                    ra_lvl    = lvl_dec;
                    ra_node   = lift_u;
                end
                else
                begin
                    dw_en   = 1'b1;
                    dw_node = cnt_reg[NODE_W-1:0];
                    dw_data = dsat;
                    if (cnt_inc < live_n)
                    begin
                        cnt_next   = cnt_inc;
                        state_next = S_DEP_A;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_Q_SWAP:
            begin
                rb_en    = 1'b1;
                lvl_next = '0;
                if (dep_a_reg > dep_b_reg)
                begin
                    u_next    = v_reg;
                    v_next    = u_reg;
                    diff_next = dep_a_reg - dep_b_reg;
                    rb_node   = u_reg;
                end
                else
                begin
                    diff_next = dep_b_reg - dep_a_reg;
                    rb_node   = v_reg;
                end
                state_next = S_Q_LIFT;
            end

            S_Q_LIFT:
            begin
                // The depth difference is consumed one bit per level.
                v_next    = v_lifted;
                diff_next = diff_reg >> 1;
                if (lvl_reg != TOP_LVL)
                begin
                    lvl_next = lvl_inc;
                    rb_en    = 1'b1;
                    rb_lvl   = lvl_inc;
                    rb_node  = v_lifted;
                end
                else if (u_reg == v_lifted)
                begin
                    res_next.ancestor = u_wide[lcal_pkg::NODE_IN_W-1:0];
                    state_next        = S_DONE;
                end
                else
                begin
                    ra_en      = 1'b1;
                    ra_lvl     = lvl_reg;
                    ra_node    = u_reg;
                    rb_en      = 1'b1;
                    rb_lvl     = lvl_reg;
                    rb_node    = v_lifted;
                    state_next = S_Q_DESC;
                end
            end

            S_Q_DESC:
            begin
                u_next = u_desc;
                v_next = v_desc;
                if (lvl_reg != '0)
                begin
                    lvl_next = lvl_dec;
                    ra_en    = 1'b1;
                    ra_lvl   = lvl_dec;
                    ra_node  = u_desc;
                    rb_en    = 1'b1;
                    rb_lvl   = lvl_dec;
                    rb_node  = v_desc;
                end
                else
                begin
                    ra_en      = 1'b1;
                    ra_node    = u_desc;
                    state_next = S_Q_FIN;
                end
            end

            S_Q_FIN:
            begin
                res_next.ancestor = root_u ? '0 : fin_wide[lcal_pkg::NODE_IN_W-1:0];
                state_next        = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign result    = res_reg;

endmodule

FILE: src/lowest_common_ancestor_lifting_unit.sv
// Lowest common ancestor unit by binary lifting over an ancestor table of
// LEVELS x MAX_NODES entries and a depth store of MAX_NODES entries. One item
// is worked at a time and req is not ready until its result beat has been
// handed to the output register. A load goes straight to its result. A query
// makes one depth read, then one table step per level to lift the deeper node,
// one per level on both nodes to descend and a final parent read, all through
// a single two-read-port table memory and one shared lifting unit. A query
// whose lifted node already equals the other node ends after the lift. A build
// makes two dependent table reads per entry on each level above the first and
// walks the levels of each node in use for its depth. The tables have no
// clearing pass; every node below node_count must be loaded before a build.
`timescale 1ns / 1ps

module lowest_common_ancestor_lifting_unit #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input logic         clk,
    input logic         rst_n,
    lcal_chan_if.sink   req,
    lcal_chan_if.source rsp,
    lcal_chan_if.sink   cfg
);

    lcal_pkg::lcal_count_t  node_count_reg;
    logic                   rsp_valid_reg;
    lcal_pkg::lcal_result_t rsp_data_reg;

    logic                   eng_idle;
    logic                   eng_valid;
    logic                   eng_ready;
    lcal_pkg::lcal_result_t eng_result;
    lcal_pkg::lcal_item_t   req_item;

    assign req_item  = req.data;
    assign req.ready = eng_idle;
    assign cfg.ready = 1'b1;

    // The output register takes a new beat when empty or being drained.
    assign eng_ready = !rsp_valid_reg || rsp.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= lcal_pkg::COUNT_W'(1);
        end
        else if (cfg.valid)
        begin
            node_count_reg <= lcal_pkg::COUNT_W'(cfg.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eng_ready)
        begin
            rsp_valid_reg <= eng_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_ready && eng_valid)
        begin
            rsp_data_reg <= eng_result;
        end
    end

    lcal_engine #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req.valid && eng_idle),
        .idle       (eng_idle),
        .item       (req_item),
        .node_count (node_count_reg),
        .res_valid  (eng_valid),
        .res_ready  (eng_ready),
        .result     (eng_result)
    );

endmodule
